[rtl/rsp_packet_deframer_core_macros.svh]
// assertion macros for the remote serial protocol packet deframer
// used by rsp_packet_deframer_core; no other dependencies
`ifndef RSP_PACKET_DEFRAMER_CORE_MACROS_SVH
`define RSP_PACKET_DEFRAMER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// plain property check on the rising clock, off while reset is held
`define RPD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("rsp deframer assertion failed");
// same-cycle implication
`define RPD_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  `RPD_ASSERT(lbl, clk, rstn, (ante) |-> (cons))
`else
`define RPD_ASSERT(lbl, clk, rstn, prop)
`define RPD_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`endif

`endif

[rtl/rpd_pkg.sv]
// package for the remote serial protocol packet deframer
// types, character constants and the hex digit decoder; no dependencies
`default_nettype none

package rpd_pkg;

  localparam int unsigned MAX_PAYLOAD = 4096;

  localparam int unsigned RX_W   = 8;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned KIND_W = 2;

  localparam logic [CHAR_W-1:0] CH_START = 7'h24;  // '$'
  localparam logic [CHAR_W-1:0] CH_END   = 7'h23;  // '#'
  localparam logic [CHAR_W-1:0] CH_ACK   = 7'h2b;  // '+'
  localparam logic [CHAR_W-1:0] CH_NAK   = 7'h2d;  // '-'

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BODY = 2'd1,
    PH_HIGH = 2'd2,
    PH_LOW  = 2'd3
  } phase_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_HEX_ERR = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [CHAR_W-1:0]  data_byte;
    logic [LEN_W-1:0]   packet_length;
    logic               length_overflow;
    logic               reply_valid;
    logic [CHAR_W-1:0]  reply_byte;
    logic               last;
  } result_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } hex_t;

  // lower-case hex only
  function automatic hex_t hex_decode(input logic [CHAR_W-1:0] c);
    hex_t h;
    h.bad   = 1'b0;
    h.value = c[3:0];
    if (c >= 7'h30 && c <= 7'h39) begin
      h.value = c[3:0];
    end else if (c >= 7'h61 && c <= 7'h66) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.bad   = 1'b1;
      h.value = 4'd0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

[rtl/rpd_if.sv]
// valid/ready channels of the remote serial protocol packet deframer
// depends on rpd_pkg for the field widths
`default_nettype none

interface rpd_rx_if;
  import rpd_pkg::*;
  logic            valid;
  logic            ready;
  logic [RX_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rpd_res_if;
  import rpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] data_byte;
  logic [LEN_W-1:0]  packet_length;
  logic              length_overflow;
  logic              reply_valid;
  logic [CHAR_W-1:0] reply_byte;
  logic              last;
  modport source (output valid, output kind, output data_byte, output packet_length,
                  output length_overflow, output reply_valid, output reply_byte,
                  output last, input ready);
  modport sink (input valid, input kind, input data_byte, input packet_length,
                input length_overflow, input reply_valid, input reply_byte,
                input last, output ready);
endinterface

interface rpd_cfg_if;
  logic valid;
  logic ready;
  logic ack_off;
  modport source (output valid, output ack_off, input ready);
  modport sink (input valid, input ack_off, output ready);
endinterface

`default_nettype wire

[rtl/rsp_packet_deframer_core.sv]
// Remote serial protocol packet deframer. Takes one received byte per request on rx_i
// (bit 7 dropped), hunts for '$', passes each body byte out on res_o as a payload
// result while summing and counting it, and after '#' checks the two lower-case hex
// checksum digits, giving a good, bad-checksum or invalid-digit verdict; good carries '+'
// (none when ack_off is set) and bad carries '-'. A byte is accepted in every cycle in
// which the result register is empty or being drained; its result follows in the next cycle.
// The rate is set by the per-byte update of phase, sum and count.
// Configuration (ack_off) is written on cfg_i, always ready.
// Depends on rpd_pkg, rpd_if.sv and rsp_packet_deframer_core_macros.svh.
`default_nettype none
`include "rsp_packet_deframer_core_macros.svh"

module rsp_packet_deframer_core #(
  parameter int unsigned MaxPayload = rpd_pkg::MAX_PAYLOAD
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rpd_rx_if.sink    rx_i,
  rpd_res_if.source res_o,
  rpd_cfg_if.sink   cfg_i
);
  import rpd_pkg::*;

  localparam int unsigned CntW = $clog2(MaxPayload + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxPayload);

  phase_e            phase_q, phase_d;
  logic [7:0]        sum_q, sum_d;
  logic [3:0]        high_q, high_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic              no_ack_q;
  logic              res_valid_q;
  result_t           res_q, res_d;

  logic              rx_acc;
  logic              has_res;
  logic [CHAR_W-1:0] c;
  hex_t              hex;
  logic [7:0]        rx_sum;

  assign c      = rx_i.rx_byte[CHAR_W-1:0];
  assign hex    = hex_decode(c);
  assign rx_sum = {high_q, hex.value};

  assign rx_i.ready  = !res_valid_q || res_o.ready;
  assign rx_acc      = rx_i.valid && rx_i.ready;
  assign cfg_i.ready = 1'b1;

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_HUNT: if (c == CH_START) phase_d = PH_BODY;
      PH_BODY: if (c == CH_END) phase_d = PH_HIGH;
      PH_HIGH: phase_d = hex.bad ? PH_HUNT : PH_LOW;
      PH_LOW:  phase_d = PH_HUNT;
      default: phase_d = PH_HUNT;
    endcase
  end

  // datapath and result
  always_comb begin
    sum_d   = sum_q;
    high_d  = high_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    has_res = 1'b0;
    res_d   = '0;
    unique case (phase_q)
      PH_HUNT: begin
        if (c == CH_START) begin
          sum_d = '0;
          cnt_d = '0;
          ovf_d = 1'b0;
        end
      end
      PH_BODY: begin
        if (c != CH_END) begin
          sum_d = sum_q + {1'b0, c};
          if (cnt_q < CntMax) begin
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          has_res         = 1'b1;
          res_d.kind      = KIND_PAYLOAD;
          res_d.data_byte = c;
        end
      end
      PH_HIGH: begin
        if (hex.bad) begin
          has_res    = 1'b1;
          res_d.kind = KIND_HEX_ERR;
          res_d.last = 1'b1;
        end else begin
          high_d = hex.value;
        end
      end
      PH_LOW: begin
        has_res    = 1'b1;
        res_d.last = 1'b1;
        if (hex.bad) begin
          res_d.kind = KIND_HEX_ERR;
        end else if (rx_sum == sum_q) begin
          res_d.kind        = KIND_GOOD;
          res_d.reply_valid = !no_ack_q;
          res_d.reply_byte  = no_ack_q ? '0 : CH_ACK;
        end else begin
          res_d.kind        = KIND_BAD;
          res_d.reply_valid = 1'b1;
          res_d.reply_byte  = CH_NAK;
        end
      end
      default: ;
    endcase
    res_d.packet_length   = LEN_W'(cnt_d);
    res_d.length_overflow = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      sum_q    <= '0;
      high_q   <= '0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      no_ack_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        no_ack_q <= cfg_i.ack_off;
      end
      if (rx_acc) begin
        phase_q <= phase_d;
        sum_q   <= sum_d;
        high_q  <= high_d;
        cnt_q   <= cnt_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (rx_acc && has_res) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_acc && has_res) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.kind            = res_q.kind;
  assign res_o.data_byte       = res_q.data_byte;
  assign res_o.packet_length   = res_q.packet_length;
  assign res_o.length_overflow = res_q.length_overflow;
  assign res_o.reply_valid     = res_q.reply_valid;
  assign res_o.reply_byte      = res_q.reply_byte;
  assign res_o.last            = res_q.last;

  `RPD_ASSERT_IMPLIES(a_hunt_silent, clk_i, rst_ni, rx_acc && phase_q == PH_HUNT, !has_res)
  `RPD_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntMax)
  `RPD_ASSERT_IMPLIES(a_ovf_at_max, clk_i, rst_ni, ovf_q, cnt_q == CntMax)
  `RPD_ASSERT_IMPLIES(a_reply_last, clk_i, rst_ni, res_valid_q && res_q.reply_valid, res_q.last)

endmodule

`default_nettype wire

[test/tb_rsp_packet_deframer_core.sv]
// testbench for rsp_packet_deframer_core: directed frames, then random framed traffic
// checked against a cycle-free deframer model kept in this file
// depends on rpd_pkg and the channel interfaces in rpd_if.sv
`timescale 1ns / 100ps

module tb_rsp_packet_deframer_core;
  import rpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_TAIL  = 4;

  typedef struct packed {
    logic [RX_W-1:0] rx;
    logic            typed;
    result_t         res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  rpd_rx_if  rx_if ();
  rpd_res_if res_if ();
  rpd_cfg_if cfg_if ();

  rsp_packet_deframer_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // deframer model state
  phase_e            frame_phase;
  logic [7:0]        frame_sum;
  logic [3:0]        frame_high;
  logic [LEN_W-1:0]  frame_count;
  logic              frame_ovf;
  logic              ack_disabled;

  result_t     awaited_results[$];
  int unsigned mismatches;
  int unsigned framed_items;
  int unsigned burst_left;
  int unsigned cycle_count;
  int unsigned stall_tick;
  int unsigned stall_mode;
  dir_row_t    directed_rows[25];

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // value 0..15 of a lower-case hex digit, 16 when not a digit
  function automatic logic [4:0] digit_value(input logic [CHAR_W-1:0] c);
    if (c >= 7'h30 && c <= 7'h39) begin
      return {1'b0, c[3:0]};
    end else if (c >= 7'h61 && c <= 7'h66) begin
      return 5'(c - 7'h61 + 7'd10);
    end
    return 5'd16;
  endfunction

  function automatic logic [RX_W-1:0] digit_char(input logic [3:0] v);
    logic [RX_W-1:0] b;
    b = 8'($urandom);
    b[6:0] = (v < 4'd10) ? (7'h30 + 7'(v)) : (7'h61 + 7'(v) - 7'd10);
    return b;
  endfunction

  function automatic result_t mk_result(input kind_e k, input logic [CHAR_W-1:0] d,
                                        input logic [LEN_W-1:0] len, input logic rv,
                                        input logic [CHAR_W-1:0] rb);
    result_t r;
    r = '0;
    r.kind          = k;
    r.data_byte     = d;
    r.packet_length = len;
    r.reply_valid   = rv;
    r.reply_byte    = rb;
    r.last          = (k != KIND_PAYLOAD);
    return r;
  endfunction

  function automatic bit deframe_byte(input logic [RX_W-1:0] rx, output result_t r);
    logic [CHAR_W-1:0] c;
    logic [4:0]        d;
    bit                has;
    c   = rx[CHAR_W-1:0];
    r   = '0;
    has = 1'b0;
    case (frame_phase)
      PH_HUNT: begin
        if (c == CH_START) begin
          frame_phase = PH_BODY;
          frame_sum   = '0;
          frame_count = '0;
          frame_ovf   = 1'b0;
        end
      end
      PH_BODY: begin
        if (c == CH_END) begin
          frame_phase = PH_HIGH;
        end else begin
          frame_sum = frame_sum + 8'(c);
          if (frame_count < MAX_PAYLOAD) frame_count++;
          else frame_ovf = 1'b1;
          r.kind      = KIND_PAYLOAD;
          r.data_byte = c;
          has         = 1'b1;
        end
      end
      PH_HIGH: begin
        d = digit_value(c);
        if (d[4]) begin
          frame_phase = PH_HUNT;
          r.kind      = KIND_HEX_ERR;
          r.last      = 1'b1;
          has         = 1'b1;
        end else begin
          frame_high  = d[3:0];
          frame_phase = PH_LOW;
        end
      end
      default: begin
        d = digit_value(c);
        frame_phase = PH_HUNT;
        r.last = 1'b1;
        has    = 1'b1;
        if (d[4]) begin
          r.kind = KIND_HEX_ERR;
        end else if (frame_sum == {frame_high, d[3:0]}) begin
          r.kind = KIND_GOOD;
          if (!ack_disabled) begin
            r.reply_valid = 1'b1;
            r.reply_byte  = CH_ACK;
          end
        end else begin
          r.kind        = KIND_BAD;
          r.reply_valid = 1'b1;
          r.reply_byte  = CH_NAK;
        end
      end
    endcase
    r.packet_length   = frame_count;
    r.length_overflow = frame_ovf;
    return has;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] e, input logic [15:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      mismatches++;
    end
  endtask

  task automatic check_result();
    result_t got;
    result_t exp;
    got.kind            = kind_e'(res_if.kind);
    got.data_byte       = res_if.data_byte;
    got.packet_length   = res_if.packet_length;
    got.length_overflow = res_if.length_overflow;
    got.reply_valid     = res_if.reply_valid;
    got.reply_byte      = res_if.reply_byte;
    got.last            = res_if.last;
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kind %0h length %0h",
               $time, got.kind, got.packet_length);
      mismatches++;
    end else begin
      exp = awaited_results.pop_front();
      compare_field("kind", 16'(exp.kind), 16'(got.kind));
      compare_field("data_byte", 16'(exp.data_byte), 16'(got.data_byte));
      compare_field("packet_length", 16'(exp.packet_length), 16'(got.packet_length));
      compare_field("length_overflow", 16'(exp.length_overflow), 16'(got.length_overflow));
      compare_field("reply_valid", 16'(exp.reply_valid), 16'(got.reply_valid));
      compare_field("reply_byte", 16'(exp.reply_byte), 16'(got.reply_byte));
      compare_field("last", 16'(exp.last), 16'(got.last));
    end
  endtask

  // result side: the ready pattern periodically switches to a randomly picked mode
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) check_result();
    stall_tick++;
    if (stall_tick % 50 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: res_if.ready <= 1'b1;
      1: res_if.ready <= stall_tick[0];
      2: res_if.ready <= 1'($urandom_range(0, 1));
      default: res_if.ready <= (stall_tick % 4 == 0);
    endcase
  end

  task automatic send_byte(input logic [RX_W-1:0] rx, input bit typed, input result_t typed_res);
    result_t     r;
    bit          has;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= rx;
    do @(posedge clk_i); while (!rx_if.ready);
    if (frame_phase != PH_HUNT || rx[CHAR_W-1:0] == CH_START) framed_items++;
    has = deframe_byte(rx, r);
    if (typed) awaited_results.push_back(typed_res);
    else if (has) awaited_results.push_back(r);
  endtask

  task automatic drain_results();
    rx_if.valid <= 1'b0;
    burst_left = 0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  task automatic write_no_ack(input logic v);
    cfg_if.valid   <= 1'b1;
    cfg_if.ack_off <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    ack_disabled = v;
  endtask

  task automatic send_packet(input int unsigned body_len);
    logic [7:0]      sum;
    logic [7:0]      ck;
    logic [RX_W-1:0] b;
    logic [4:0]      dv;
    int unsigned     pick;
    sum = '0;
    b = 8'($urandom);
    b[6:0] = CH_START;
    send_byte(b, 1'b0, '0);
    for (int unsigned i = 0; i < body_len; i++) begin
      b = 8'($urandom);
      if (b[6:0] == CH_END) b[0] = ~b[0];
      sum = sum + 8'(b[6:0]);
      send_byte(b, 1'b0, '0);
    end
    b = 8'($urandom);
    b[6:0] = CH_END;
    send_byte(b, 1'b0, '0);
    pick = $urandom_range(0, 99);
    ck = (pick < 70) ? sum : sum + 8'($urandom_range(1, 255));
    if (pick < 85) begin
      send_byte(digit_char(ck[7:4]), 1'b0, '0);
      send_byte(digit_char(ck[3:0]), 1'b0, '0);
    end else begin
      // one of the two digit positions carries a non-digit
      do begin
        b  = 8'($urandom);
        dv = digit_value(b[6:0]);
      end while (!dv[4]);
      if (pick < 92) begin
        send_byte(b, 1'b0, '0);
        send_byte(digit_char(ck[3:0]), 1'b0, '0);
      end else begin
        send_byte(digit_char(ck[7:4]), 1'b0, '0);
        send_byte(b, 1'b0, '0);
      end
    end
  endtask

  task automatic run_random(input int unsigned count, input bit pause_midway);
    int unsigned start;
    bit          paused;
    start  = framed_items;
    paused = 1'b0;
    while (framed_items - start < count) begin
      if ($urandom_range(0, 9) < 3) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, '0);
      end
      if ($urandom_range(0, 99) < 85) send_packet($urandom_range(0, 12));
      else send_packet($urandom_range(13, 80));
      if (pause_midway && !paused && framed_items - start >= count / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end
    drain_results();
  endtask

  initial begin
    rst_ni         = 1'b0;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.ack_off = 1'b0;
    res_if.ready   = 1'b0;
    frame_phase    = PH_HUNT;
    frame_sum      = '0;
    frame_high     = '0;
    frame_count    = '0;
    frame_ovf      = 1'b0;
    ack_disabled   = 1'b0;
    mismatches     = 0;
    framed_items   = 0;
    burst_left     = 0;
    cycle_count    = 0;
    stall_tick     = 0;
    stall_mode     = 0;

    directed_rows = '{
      '{8'h00, 1'b0, '0},
      '{8'hff, 1'b0, '0},
      '{8'ha4, 1'b0, '0},
      '{8'h7f, 1'b1, mk_result(KIND_PAYLOAD, 7'h7f, 13'd1, 1'b0, 7'h00)},
      '{8'h00, 1'b1, mk_result(KIND_PAYLOAD, 7'h00, 13'd2, 1'b0, 7'h00)},
      // start marker inside a body is plain payload
      '{8'h24, 1'b1, mk_result(KIND_PAYLOAD, 7'h24, 13'd3, 1'b0, 7'h00)},
      '{8'h23, 1'b0, '0},
      '{8'h61, 1'b0, '0},
      '{8'h33, 1'b1, mk_result(KIND_GOOD, 7'h00, 13'd3, 1'b1, CH_ACK)},
      '{8'h24, 1'b0, '0},
      '{8'h23, 1'b0, '0},
      '{8'h30, 1'b0, '0},
      '{8'h31, 1'b1, mk_result(KIND_BAD, 7'h00, 13'd0, 1'b1, CH_NAK)},
      '{8'h24, 1'b0, '0},
      '{8'h41, 1'b1, mk_result(KIND_PAYLOAD, 7'h41, 13'd1, 1'b0, 7'h00)},
      '{8'h23, 1'b0, '0},
      '{8'h67, 1'b1, mk_result(KIND_HEX_ERR, 7'h00, 13'd1, 1'b0, 7'h00)},
      '{8'h24, 1'b0, '0},
      '{8'h23, 1'b0, '0},
      '{8'h66, 1'b0, '0},
      // a letter past 'f' is not accepted as a low digit
      '{8'h47, 1'b1, mk_result(KIND_HEX_ERR, 7'h00, 13'd0, 1'b0, 7'h00)},
      '{8'ha4, 1'b0, '0},
      '{8'ha3, 1'b0, '0},
      '{8'hb0, 1'b0, '0},
      '{8'h30, 1'b1, mk_result(KIND_GOOD, 7'h00, 13'd0, 1'b1, CH_ACK)}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_no_ack(1'b0);
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].res);
    end
    drain_results();

    write_no_ack(1'b1);
    run_random(300, 1'b0);

    // one frame past the payload limit, then normal traffic
    write_no_ack(1'b0);
    send_packet(MAX_PAYLOAD + 3);
    run_random(300, 1'b0);

    write_no_ack(1'b1);
    run_random(300, 1'b1);

    write_no_ack(1'($urandom_range(0, 1)));
    run_random(350, 1'b0);

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/rpd_pkg.sv
rtl/rpd_if.sv
rtl/rsp_packet_deframer_core.sv
test/tb_rsp_packet_deframer_core.sv
